// File: hw/rtl/svse_pkg.sv
package svse_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned TRI_W   = 12;
  localparam int unsigned OTHER_W = 13;
  localparam int unsigned IDX_W   = 20;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned CAP_W   = 15;
  localparam int unsigned SIDE_W  = 17;
  localparam int unsigned KIND_W  = 2;

  // Dot product datapath: vertex minus light needs one extra bit
  localparam int unsigned A_W    = COORD_W + 1;
  localparam int unsigned NH_W   = 17;
  localparam int unsigned PROD_W = A_W + NH_W;
  localparam int unsigned ACC_W  = 2 * COORD_W + 3;

  localparam int unsigned IN_DATA_W  = 280;
  localparam int unsigned OUT_DATA_W = 96;

  localparam int unsigned DEF_MAX_TRIANGLES = 4096;

  localparam logic [CAP_W-1:0]  CAP_SAT  = 15'd32767;
  localparam logic [SIDE_W-1:0] SIDE_SAT = 17'd131071;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKE_CAPS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_NORMALS = 3'd5;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TRI    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_CAP  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIDE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  // Input beat, first field in the lowest bits
  typedef struct packed {
    logic [2:0]                pad;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] normal_z;
    logic signed [COORD_W-1:0] normal_y;
    logic signed [COORD_W-1:0] normal_x;
    logic [IDX_W-1:0]          vert_c;
    logic [IDX_W-1:0]          vert_b;
    logic [IDX_W-1:0]          vert_a;
    logic [OTHER_W-1:0]        other_tri;
    logic [TRI_W-1:0]          tri_index;
  } in_beat_t;

  // Result beat, first field in the lowest bits
  typedef struct packed {
    logic [3:0]        pad;
    logic [SIDE_W-1:0] side_count;
    logic [CAP_W-1:0]  cap_count;
    logic [IDX_W-1:0]  idx_third;
    logic [IDX_W-1:0]  idx_second;
    logic [IDX_W-1:0]  idx_first;
  } out_beat_t;

  // Status of the dot product unit
  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } dot_res_t;

endpackage

// File: hw/rtl/shadow_volume_silhouette_emitter_top.sv
// Shadow volume silhouette emitter. Triangle beats (tuser 0) are tested
// against the light with one shared 33x17 multiplier that works through six
// partial products, and a triangle holds the block until its cap triangles
// are emitted. Edge beats (tuser 1) read the two facing bits one after the
// other through the single read port of the facing memory, then emit their
// side triangles. A finish beat (tuser 2) returns the cap and side index
// counts, then clears them. in_tready is low while a beat is being worked
// on; the last result sits in the output register so the next beat can be
// taken while it waits. Facing bits are not cleared at reset: an edge must
// only name triangles already sent. Configuration is written through the
// cfg port by the user only while idle; the block does not enforce this.
module shadow_volume_silhouette_emitter_top #(
  parameter int unsigned MAX_TRIANGLES = svse_pkg::DEF_MAX_TRIANGLES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata: tri_index, other_tri, vert_a, vert_b, vert_c, normal_x, normal_y,
  // normal_z, point_x, point_y, point_z, zero pad
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [svse_pkg::IN_DATA_W-1:0]       in_tdata,
  // tuser: cmd
  input  logic [svse_pkg::CMD_W-1:0]           in_tuser,
  // tdata: idx_first, idx_second, idx_third, cap_count, side_count, zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [svse_pkg::OUT_DATA_W-1:0]      out_tdata,
  // tuser: kind
  output logic [svse_pkg::KIND_W-1:0]          out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [svse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [svse_pkg::COORD_W-1:0]         cfg_data
);

  localparam int unsigned TRI_AW  = $clog2(MAX_TRIANGLES);
  localparam int unsigned A_W     = svse_pkg::A_W;
  localparam int unsigned IDX_W   = svse_pkg::IDX_W;
  localparam int unsigned COORD_W = svse_pkg::COORD_W;
  localparam int unsigned CAP_W   = svse_pkg::CAP_W;
  localparam int unsigned SIDE_W  = svse_pkg::SIDE_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DOT  = 5'b00010,
    ST_RD0  = 5'b00100,
    ST_RD1  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  svse_pkg::in_beat_t  in_beat;
  svse_pkg::out_beat_t out_beat_nxt;
  svse_pkg::out_beat_t out_beat_r;
  svse_pkg::dot_res_t  dot_res;

  state_t state_r, state_nxt;

  // Configuration registers
  logic                      kind_r;
  logic signed [COORD_W-1:0] lx_r, ly_r, lz_r;
  logic                      caps_r;
  logic                      flip_r;

  // Item registers
  logic [svse_pkg::TRI_W-1:0]   tri_r;
  logic [svse_pkg::OTHER_W-1:0] other_r;
  logic [IDX_W-1:0]             va_r, vb_r, vc_r;
  logic [IDX_W-1:0]             va_nxt, vb_nxt;
  logic                         f0_r, f0_nxt;
  logic [svse_pkg::KIND_W-1:0]  ekind_r, ekind_nxt;
  logic                         two_r, two_nxt;
  logic                         half_r, half_nxt;

  // Counters and output register
  logic [CAP_W-1:0]             cap_r, cap_nxt;
  logic [SIDE_W-1:0]            side_r, side_nxt;
  logic                         out_vld_r, out_vld_nxt;
  logic [svse_pkg::KIND_W-1:0]  out_kind_r;
  logic                         out_last_r;
  logic                         out_last_nxt;
  logic                         out_load;

  logic                         in_fire;
  logic                         dot_start;
  logic signed [A_W-1:0]        a_vec [3];
  logic signed [COORD_W-1:0]    n_vec [3];
  logic                         tri_ok;
  logic                         other_ok;
  logic                         facing;
  logic                         out_free;
  logic                         ram_we;
  logic [TRI_AW-1:0]            ram_raddr;
  logic                         ram_rdata;
  logic                         f1;

  assign in_beat   = in_tdata;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= 1'b0;
      lx_r   <= '0;
      ly_r   <= '0;
      lz_r   <= '0;
      caps_r <= 1'b0;
      flip_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        svse_pkg::CFG_LIGHT_KIND:   kind_r <= cfg_data[0];
        svse_pkg::CFG_LIGHT_X:      lx_r   <= cfg_data;
        svse_pkg::CFG_LIGHT_Y:      ly_r   <= cfg_data;
        svse_pkg::CFG_LIGHT_Z:      lz_r   <= cfg_data;
        svse_pkg::CFG_MAKE_CAPS:    caps_r <= cfg_data[0];
        svse_pkg::CFG_FLIP_NORMALS: flip_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Light vector: direction, or vertex minus light position
  always_comb begin
    if (kind_r) begin
      a_vec[0] = A_W'(in_beat.point_x) - A_W'(lx_r);
      a_vec[1] = A_W'(in_beat.point_y) - A_W'(ly_r);
      a_vec[2] = A_W'(in_beat.point_z) - A_W'(lz_r);
    end else begin
      a_vec[0] = A_W'(lx_r);
      a_vec[1] = A_W'(ly_r);
      a_vec[2] = A_W'(lz_r);
    end
    n_vec[0] = in_beat.normal_x;
    n_vec[1] = in_beat.normal_y;
    n_vec[2] = in_beat.normal_z;
  end

  assign dot_start = in_fire && (in_tuser == svse_pkg::CMD_TRI);

  svse_dot u_dot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dot_start),
    .a_in  (a_vec),
    .n_in  (n_vec),
    .res   (dot_res)
  );

  // Facing decision; a zero dot product never faces
  assign facing = flip_r ? (!dot_res.neg && !dot_res.zero) : dot_res.neg;

  assign tri_ok   = (32'(tri_r) < 32'(MAX_TRIANGLES));
  assign other_ok = (32'(other_r) < 32'(MAX_TRIANGLES));

  // Facing bit store: first triangle read on accept, second in ST_RD0
  assign ram_we    = (state_r == ST_DOT) && dot_res.done && tri_ok;
  assign ram_raddr = (state_r == ST_RD0) ? TRI_AW'(other_r) : TRI_AW'(in_beat.tri_index);

  svse_ram #(
    .WIDTH (1),
    .DEPTH (MAX_TRIANGLES)
  ) u_facing_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (TRI_AW'(tri_r)),
    .wr_data (facing),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign f1       = other_ok && ram_rdata;
  assign out_free = !out_vld_r || out_tready;

  // Build the pending result from the held item
  always_comb begin
    out_beat_nxt = '0;
    out_last_nxt = !(two_r && !half_r);
    unique case (ekind_r)
      svse_pkg::KIND_CAP: begin
        if (half_r) begin
          out_beat_nxt.idx_first  = vc_r + IDX_W'(1);
          out_beat_nxt.idx_second = vb_r + IDX_W'(1);
          out_beat_nxt.idx_third  = va_r + IDX_W'(1);
        end else begin
          out_beat_nxt.idx_first  = va_r;
          out_beat_nxt.idx_second = vb_r;
          out_beat_nxt.idx_third  = vc_r;
        end
      end
      svse_pkg::KIND_SIDE: begin
        if (half_r) begin
          out_beat_nxt.idx_first  = vb_r + IDX_W'(1);
          out_beat_nxt.idx_second = va_r + IDX_W'(1);
          out_beat_nxt.idx_third  = va_r;
        end else begin
          out_beat_nxt.idx_first  = va_r;
          out_beat_nxt.idx_second = vb_r;
          out_beat_nxt.idx_third  = vb_r + IDX_W'(1);
        end
      end
      svse_pkg::KIND_DONE: begin
        out_beat_nxt.cap_count  = cap_r;
        out_beat_nxt.side_count = side_r;
      end
      default: ;
    endcase
  end

  assign out_load = (state_r == ST_EMIT) && out_free;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    va_nxt      = va_r;
    vb_nxt      = vb_r;
    f0_nxt      = f0_r;
    ekind_nxt   = ekind_r;
    two_nxt     = two_r;
    half_nxt    = half_r;
    cap_nxt     = cap_r;
    side_nxt    = side_r;
    out_vld_nxt = out_vld_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          va_nxt   = in_beat.vert_a;
          vb_nxt   = in_beat.vert_b;
          half_nxt = 1'b0;
          unique case (in_tuser)
            svse_pkg::CMD_TRI: begin
              state_nxt = ST_DOT;
              ekind_nxt = svse_pkg::KIND_CAP;
              two_nxt   = kind_r;
            end
            svse_pkg::CMD_EDGE: begin
              state_nxt = ST_RD0;
              ekind_nxt = svse_pkg::KIND_SIDE;
              two_nxt   = kind_r;
            end
            svse_pkg::CMD_FINISH: begin
              state_nxt = ST_EMIT;
              ekind_nxt = svse_pkg::KIND_DONE;
              two_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_DOT: begin
        if (dot_res.done) begin
          state_nxt = (caps_r && facing) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_RD0: begin
        f0_nxt    = tri_ok && ram_rdata;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        if (f0_r != f1) begin
          state_nxt = ST_EMIT;
          // Swap so that the first vertex register holds p
          if (f0_r) begin
            va_nxt = vb_r;
            vb_nxt = va_r;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          unique case (ekind_r)
            svse_pkg::KIND_CAP: begin
              cap_nxt = (cap_r > svse_pkg::CAP_SAT - CAP_W'(3)) ?
                        svse_pkg::CAP_SAT : cap_r + CAP_W'(3);
            end
            svse_pkg::KIND_SIDE: begin
              side_nxt = (side_r > svse_pkg::SIDE_SAT - SIDE_W'(3)) ?
                         svse_pkg::SIDE_SAT : side_r + SIDE_W'(3);
            end
            svse_pkg::KIND_DONE: begin
              cap_nxt  = '0;
              side_nxt = '0;
            end
            default: ;
          endcase
          if (two_r && !half_r) begin
            half_nxt = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cap_r     <= '0;
      side_r    <= '0;
      out_vld_r <= 1'b0;
      half_r    <= 1'b0;
      two_r     <= 1'b0;
      ekind_r   <= svse_pkg::KIND_CAP;
      f0_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cap_r     <= cap_nxt;
      side_r    <= side_nxt;
      out_vld_r <= out_vld_nxt;
      half_r    <= half_nxt;
      two_r     <= two_nxt;
      ekind_r   <= ekind_nxt;
      f0_r      <= f0_nxt;
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    va_r <= va_nxt;
    vb_r <= vb_nxt;
    if (in_fire) begin
      tri_r   <= in_beat.tri_index;
      other_r <= in_beat.other_tri;
      vc_r    <= in_beat.vert_c;
    end
  end

  // Output register: load a beat when the slot is free
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_beat_r <= out_beat_nxt;
      out_kind_r <= ekind_r;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_beat_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hw/rtl/svse_ram.sv
module svse_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/svse_dot.sv
module svse_dot (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [svse_pkg::A_W-1:0]       a_in [3],
  input  logic signed [svse_pkg::COORD_W-1:0]   n_in [3],
  output svse_pkg::dot_res_t                    res
);

  localparam int unsigned A_W    = svse_pkg::A_W;
  localparam int unsigned NH_W   = svse_pkg::NH_W;
  localparam int unsigned PROD_W = svse_pkg::PROD_W;
  localparam int unsigned ACC_W  = svse_pkg::ACC_W;
  localparam logic [2:0]  LAST_STEP = 3'd6;

  logic signed [A_W-1:0]             a_r [3];
  logic signed [svse_pkg::COORD_W-1:0] n_r [3];
  logic                              busy_r;
  logic [2:0]                        step_r;
  logic signed [PROD_W-1:0]          prod_r;
  logic                              prod_vld_r;
  logic                              prod_hi_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic                              done_r;

  logic signed [A_W-1:0]             a_sel;
  logic signed [svse_pkg::COORD_W-1:0] n_sel;
  logic signed [NH_W-1:0]            n_part;
  logic signed [PROD_W-1:0]          prod_nxt;
  logic signed [ACC_W-1:0]           prod_ext;
  logic signed [ACC_W-1:0]           addend;

  // Pick the operand pair of this step: even steps take the low normal
  // half (unsigned), odd steps the high half (signed)
  always_comb begin
    unique case (step_r[2:1])
      2'd0: begin a_sel = a_r[0]; n_sel = n_r[0]; end
      2'd1: begin a_sel = a_r[1]; n_sel = n_r[1]; end
      2'd2: begin a_sel = a_r[2]; n_sel = n_r[2]; end
      default: begin a_sel = '0; n_sel = '0; end
    endcase
    if (step_r[0]) begin
      n_part = NH_W'(n_sel >>> 16);
    end else begin
      n_part = {1'b0, n_sel[15:0]};
    end
  end

  // Shared multiplier
  assign prod_nxt = a_sel * n_part;

  // Align the registered product for accumulation
  assign prod_ext = ACC_W'(prod_r);
  assign addend   = prod_hi_r ? (prod_ext <<< 16) : prod_ext;

  // Sequence the six partial products and accumulate them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      step_r     <= '0;
      prod_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r     <= busy_r && (step_r == LAST_STEP);
      prod_vld_r <= busy_r && !start && (step_r != LAST_STEP);
      if (start) begin
        busy_r     <= 1'b1;
        step_r     <= '0;
      end else if (busy_r) begin
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  // Payload: operands, product and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_in;
      n_r   <= n_in;
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + addend;
    end
    prod_r    <= prod_nxt;
    prod_hi_r <= step_r[0];
  end

  assign res.done = done_r;
  assign res.neg  = acc_r[ACC_W-1];
  assign res.zero = (acc_r == '0);

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import svse_pkg::*;

  localparam int unsigned TRI_SLOTS   = DEF_MAX_TRIANGLES;
  // A triangle beat holds the block until its cap triangles are emitted
  localparam int unsigned IDLE_CYCLES = 20;
  localparam int unsigned RANDOM_BEATS = 1900;
  // Command code the block does not know
  localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

  // One expected emitted triangle or done report
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  second;
    logic [IDX_W-1:0]  third;
    logic              last;
    logic [CAP_W-1:0]  caps;
    logic [SIDE_W-1:0] sides;
  } emit_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COORD_W-1:0]    cfg_data = '0;

  // Predictor state: light setup, facing memory and index counters
  logic                      pos_light = 1'b0;
  logic signed [COORD_W-1:0] light_x = '0;
  logic signed [COORD_W-1:0] light_y = '0;
  logic signed [COORD_W-1:0] light_z = '0;
  logic                      caps_on = 1'b0;
  logic                      flip_on = 1'b0;
  logic                      facing_mem [TRI_SLOTS];
  logic                      facing_known [TRI_SLOTS];
  logic [TRI_W-1:0]          tri_pool [$];
  int                        cap_total = 0;
  int                        side_total = 0;

  emit_t emit_q [$];
  int    errors = 0;
  logic  calm = 1'b0;
  int    stall_left = 0;

  shadow_volume_silhouette_emitter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t tri_beat(logic [TRI_W-1:0] idx, logic [IDX_W-1:0] a,
                                        logic [IDX_W-1:0] b, logic [IDX_W-1:0] c,
                                        logic [COORD_W-1:0] nx, logic [COORD_W-1:0] ny,
                                        logic [COORD_W-1:0] nz, logic [COORD_W-1:0] px,
                                        logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz);
    in_beat_t t;
    t = '0;
    t.tri_index = idx;
    t.other_tri = 13'($urandom);
    t.vert_a = a;
    t.vert_b = b;
    t.vert_c = c;
    t.normal_x = nx;
    t.normal_y = ny;
    t.normal_z = nz;
    t.point_x = px;
    t.point_y = py;
    t.point_z = pz;
    return t;
  endfunction

  // Edge beat: fields an edge ignores carry noise
  function automatic in_beat_t edge_beat(logic [TRI_W-1:0] t0, logic [OTHER_W-1:0] t1,
                                         logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    in_beat_t t;
    t = tri_beat(t0, a, b, 20'($urandom), $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
    t.other_tri = t1;
    return t;
  endfunction

  function automatic int sat_add(int v, int n, int top);
    return (v + n > top) ? top : v + n;
  endfunction

  function automatic void push_emit(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] f,
                                    logic [IDX_W-1:0] s, logic [IDX_W-1:0] t, logic last,
                                    int caps, int sides);
    emit_t e;
    e.kind = kind;
    e.first = f;
    e.second = s;
    e.third = t;
    e.last = last;
    e.caps = CAP_W'(caps);
    e.sides = SIDE_W'(sides);
    emit_q.push_back(e);
  endfunction

  // Work out the emitted triangles and reports of one accepted beat
  function automatic void predict_beat(logic [CMD_W-1:0] cmd, in_beat_t b);
    logic signed [33:0]        ax, ay, az;
    logic signed [COORD_W-1:0] nx, ny, nz;
    logic signed [69:0]        dot;
    logic                      faces, f0, f1;
    logic [IDX_W-1:0]          p, q;
    nx = b.normal_x;
    ny = b.normal_y;
    nz = b.normal_z;
    case (cmd)
      CMD_TRI: begin
        if (pos_light) begin
          ax = $signed(b.point_x);
          ay = $signed(b.point_y);
          az = $signed(b.point_z);
          ax = ax - light_x;
          ay = ay - light_y;
          az = az - light_z;
        end else begin
          ax = light_x;
          ay = light_y;
          az = light_z;
        end
        dot = ax * nx + ay * ny + az * nz;
        faces = flip_on ? (dot > 0) : (dot < 0);
        if (!facing_known[b.tri_index]) begin
          facing_known[b.tri_index] = 1'b1;
          tri_pool.push_back(b.tri_index);
        end
        facing_mem[b.tri_index] = faces;
        if (caps_on && faces) begin
          if (!pos_light) begin
            push_emit(KIND_CAP, b.vert_a, b.vert_b, b.vert_c, 1'b1, 0, 0);
            cap_total = sat_add(cap_total, 3, int'(CAP_SAT));
          end else begin
            push_emit(KIND_CAP, b.vert_a, b.vert_b, b.vert_c, 1'b0, 0, 0);
            push_emit(KIND_CAP, b.vert_c + 1'b1, b.vert_b + 1'b1, b.vert_a + 1'b1, 1'b1, 0, 0);
            cap_total = sat_add(cap_total, 6, int'(CAP_SAT));
          end
        end
      end
      CMD_EDGE: begin
        f0 = facing_mem[b.tri_index];
        f1 = (b.other_tri < TRI_SLOTS) ? facing_mem[b.other_tri[TRI_W-1:0]] : 1'b0;
        if (f0 != f1) begin
          p = f0 ? b.vert_b : b.vert_a;
          q = f0 ? b.vert_a : b.vert_b;
          if (!pos_light) begin
            push_emit(KIND_SIDE, p, q, q + 1'b1, 1'b1, 0, 0);
            side_total = sat_add(side_total, 3, int'(SIDE_SAT));
          end else begin
            push_emit(KIND_SIDE, p, q, q + 1'b1, 1'b0, 0, 0);
            push_emit(KIND_SIDE, q + 1'b1, p + 1'b1, p, 1'b1, 0, 0);
            side_total = sat_add(side_total, 6, int'(SIDE_SAT));
          end
        end
      end
      CMD_FINISH: begin
        push_emit(KIND_DONE, '0, '0, '0, 1'b1, cap_total, side_total);
        cap_total = 0;
        side_total = 0;
      end
      default: ;
    endcase
  endfunction

  // Present one beat after a random gap; valid stays high afterwards
  task automatic send_beat(logic [CMD_W-1:0] cmd, in_beat_t b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= cmd;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predict_beat(cmd, b);
  endtask

  // Drop valid, drain every expected result, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (emit_q.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers once the block is idle
  task automatic set_regs(logic kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          logic [COORD_W-1:0] z, logic caps, logic flip);
    logic [CFG_IDX_W-1:0] idx_list [6];
    logic [COORD_W-1:0]   val_list [6];
    wait_idle();
    idx_list = '{CFG_LIGHT_KIND, CFG_LIGHT_X, CFG_LIGHT_Y, CFG_LIGHT_Z,
                 CFG_MAKE_CAPS, CFG_FLIP_NORMALS};
    val_list = '{32'(kind), x, y, z, 32'(caps), 32'(flip)};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data <= val_list[i];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      case (idx_list[i])
        CFG_LIGHT_KIND:   pos_light = val_list[i][0];
        CFG_LIGHT_X:      light_x = val_list[i];
        CFG_LIGHT_Y:      light_y = val_list[i];
        CFG_LIGHT_Z:      light_z = val_list[i];
        CFG_MAKE_CAPS:    caps_on = val_list[i][0];
        CFG_FLIP_NORMALS: flip_on = val_list[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Compare one result beat with the oldest expectation
  task automatic check_emit();
    out_beat_t got;
    emit_t     want;
    got = out_tdata;
    if (emit_q.size() == 0) begin
      $error("unexpected result beat, kind %0d", out_tuser);
      errors++;
      return;
    end
    want = emit_q.pop_front();
    if (out_tuser !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, out_tuser);
      errors++;
    end
    if (got.idx_first !== want.first) begin
      $error("idx_first: expected %0h, got %0h", want.first, got.idx_first);
      errors++;
    end
    if (got.idx_second !== want.second) begin
      $error("idx_second: expected %0h, got %0h", want.second, got.idx_second);
      errors++;
    end
    if (got.idx_third !== want.third) begin
      $error("idx_third: expected %0h, got %0h", want.third, got.idx_third);
      errors++;
    end
    if (out_tlast !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, out_tlast);
      errors++;
    end
    if (got.cap_count !== want.caps) begin
      $error("cap_count: expected %0d, got %0d", want.caps, got.cap_count);
      errors++;
    end
    if (got.side_count !== want.sides) begin
      $error("side_count: expected %0d, got %0d", want.sides, got.side_count);
      errors++;
    end
    if (got.pad !== '0) begin
      $error("pad: expected 0, got %0h", got.pad);
      errors++;
    end
  endtask

  // Result side: check each beat, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) check_emit();
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Reset setup: zero light never faces, so nothing but the empty report
  task automatic test_reset_state();
    send_beat(CMD_TRI, tri_beat(0, 20'h0, 20'h2, 20'h4, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h1, $urandom, $urandom, $urandom));
    send_beat(CMD_TRI, tri_beat(1, 20'h6, 20'h8, 20'hA, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom));
    send_beat(CMD_EDGE, edge_beat(0, 1, 20'h0, 20'h2));
    send_beat(CMD_FINISH, edge_beat(0, 0, 20'h0, 20'h0));
  endtask

  // Directional light at the coordinate extremes, caps, sides, flipping
  task automatic test_directional();
    set_regs(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0);
    send_beat(CMD_TRI, tri_beat(2, 20'hFFFFF, 20'h0, 20'h2A, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                $urandom, $urandom, $urandom));
    send_beat(CMD_TRI, tri_beat(3, 20'h10, 20'hFFFFE, 20'h12, 32'h0, 32'h7FFF_FFFF, 32'h0,
                                $urandom, $urandom, $urandom));
    // Silhouette both ways round, single-sided, and a quiet one
    send_beat(CMD_EDGE, edge_beat(2, 3, 20'hFFFFF, 20'hFFFFE));
    send_beat(CMD_EDGE, edge_beat(3, 2, 20'hFFFFE, 20'hFFFFF));
    send_beat(CMD_EDGE, edge_beat(2, 13'd4096, 20'h4, 20'hFFFFF));
    send_beat(CMD_EDGE, edge_beat(3, 13'h1FFF, 20'h8, 20'hA));
    // Unknown command: dropped without a result
    send_beat(CMD_BAD, tri_beat(2, 20'h0, 20'h0, 20'h0, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                $urandom, $urandom, $urandom));
    set_regs(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1);
    send_beat(CMD_TRI, tri_beat(3, 20'h10, 20'hFFFFE, 20'h12, 32'h0, 32'h7FFF_FFFF, 32'h0,
                                $urandom, $urandom, $urandom));
    send_beat(CMD_FINISH, edge_beat(0, 0, 20'h0, 20'h0));
  endtask

  // Positional light: extruded caps and sides, zero normal, caps off
  task automatic test_positional();
    set_regs(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    send_beat(CMD_TRI, tri_beat(4, 20'hFFFFF, 20'hFFFFE, 20'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_beat(CMD_TRI, tri_beat(5, 20'h20, 20'h22, 20'h24, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_beat(CMD_TRI, tri_beat(6, 20'h30, 20'h32, 20'h34, 32'h0, 32'h0, 32'h0,
                                $urandom, $urandom, $urandom));
    send_beat(CMD_EDGE, edge_beat(4, 5, 20'hFFFFF, 20'h22));
    send_beat(CMD_EDGE, edge_beat(5, 4, 20'h22, 20'hFFFFF));
    send_beat(CMD_EDGE, edge_beat(4, 13'd4096, 20'hFFFFE, 20'hFFFFF));
    send_beat(CMD_EDGE, edge_beat(6, 5, 20'h30, 20'h20));
    send_beat(CMD_FINISH, edge_beat(0, 0, 20'h0, 20'h0));
    set_regs(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    send_beat(CMD_TRI, tri_beat(4, 20'hFFFFF, 20'hFFFFE, 20'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_beat(CMD_FINISH, edge_beat(0, 0, 20'h0, 20'h0));
  endtask

  // Meshes with random content under random light setups, plus noise
  task automatic test_random_mesh();
    int             counted;
    int             r;
    logic [TRI_W-1:0]   t0;
    logic [OTHER_W-1:0] t1;
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      set_regs($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord(),
               $urandom_range(0, 3) != 0, $urandom_range(0, 1));
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(40, 200)) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          t0 = ($urandom_range(0, 3) == 0) ? TRI_W'($urandom) : TRI_W'($urandom_range(0, 63));
          send_beat(CMD_TRI, tri_beat(t0, 20'($urandom), 20'($urandom), 20'($urandom),
                                      rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord()));
          counted++;
        end else if (r < 92) begin
          t0 = tri_pool[$urandom_range(0, tri_pool.size() - 1)];
          if ($urandom_range(0, 9) < 7)
            t1 = tri_pool[$urandom_range(0, tri_pool.size() - 1)];
          else
            t1 = 13'd4096 + 13'($urandom_range(0, 4095));
          send_beat(CMD_EDGE, edge_beat(t0, t1, 20'($urandom), 20'($urandom)));
          counted++;
        end else if (r < 96) begin
          send_beat(CMD_FINISH, edge_beat(TRI_W'($urandom), 13'($urandom),
                                          20'($urandom), 20'($urandom)));
          counted++;
        end else begin
          send_beat(CMD_BAD, edge_beat(TRI_W'($urandom), 13'($urandom),
                                       20'($urandom), 20'($urandom)));
        end
      end
    end
    calm = 1'b0;
    send_beat(CMD_FINISH, edge_beat(0, 0, 20'h0, 20'h0));
  endtask

  initial begin
    for (int i = 0; i < TRI_SLOTS; i++) begin
      facing_mem[i] = 1'b0;
      facing_known[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directional();
    test_positional();
    test_random_mesh();
    wait_idle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
